[hdl/tnaa_pkg.sv]
// Shared types and constants for the triangle normal and area block.
// No dependencies; used by tnaa_front, the top level and the checker.
package tnaa_pkg;

    // Coordinate width and the widths that follow from it
    localparam int COORD_BITS = 16;
    localparam int EDGE_BITS  = COORD_BITS + 1;        // b - a, c - a
    localparam int PROD_BITS  = 2 * EDGE_BITS;         // one signed edge product
    localparam int CROSS_BITS = PROD_BITS + 1;         // cross product component
    localparam int MAG_BITS   = CROSS_BITS - 1;        // magnitude of a component
    localparam int HALF_BITS  = MAG_BITS / 2;          // split for the square
    localparam int SQ_W       = 2 * MAG_BITS;          // component squared
    localparam int SUM_W      = SQ_W + 2;              // sum of three squares
    localparam int ROOT_BITS  = SUM_W / 2;             // floor(sqrt(sum))

    // Unit normal path: quotient 2^30 * m^2 / sum, then its square root
    localparam int QUO_BITS   = 31;
    localparam int DROOT_BITS = 16;

    // Result widths
    localparam int NORM_BITS  = 16;
    localparam int LEN_BITS   = 34;
    localparam int ONE_Q14    = 16384;
    localparam int LEN_W      = (ROOT_BITS > LEN_BITS) ? ROOT_BITS : LEN_BITS;
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    // Pipeline depth of the front end (edges to sum of squares)
    localparam int FRONT_STAGES = 6;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] a_z;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic signed [COORD_BITS-1:0] b_z;
        logic signed [COORD_BITS-1:0] c_x;
        logic signed [COORD_BITS-1:0] c_y;
        logic signed [COORD_BITS-1:0] c_z;
    } tri_in_t;

    typedef struct packed {
        logic signed [NORM_BITS-1:0] normal_x;
        logic signed [NORM_BITS-1:0] normal_y;
        logic signed [NORM_BITS-1:0] normal_z;
        logic [LEN_BITS-1:0]         cross_length;
        logic                        degenerate;
    } tri_out_t;

    // Front end result, also carried along the length root chain
    typedef struct packed {
        logic [SUM_W-1:0]       sum_sq;
        logic [2:0][SQ_W-1:0]   mag_sq;
        logic [2:0]             neg;
        logic                   zero;
    } front_out_t;

    // Side data carried along each normal lane
    typedef struct packed {
        logic [ROOT_BITS-1:0] len;
        logic                 neg;
        logic                 zero;
    } lane_side_t;

endpackage

[hdl/tnaa_front.sv]
// Front end: edges, cross product, component squares and their sum.
// Depends on tnaa_pkg. Six register stages, all advancing on en.
module tnaa_front (
    input  logic                   aclk,
    input  logic                   en,
    input  tnaa_pkg::tri_in_t      in_data,
    output tnaa_pkg::front_out_t   out_data
);

    localparam int CB   = tnaa_pkg::COORD_BITS;
    localparam int EB   = tnaa_pkg::EDGE_BITS;
    localparam int PB   = tnaa_pkg::PROD_BITS;
    localparam int XB   = tnaa_pkg::CROSS_BITS;
    localparam int MB   = tnaa_pkg::MAG_BITS;
    localparam int HB   = tnaa_pkg::HALF_BITS;
    localparam int SQW  = tnaa_pkg::SQ_W;
    localparam int SUMW = tnaa_pkg::SUM_W;

    logic signed [CB-1:0] a_c [3];
    logic signed [CB-1:0] b_c [3];
    logic signed [CB-1:0] c_c [3];

    logic signed [EB-1:0] e1_reg [3];
    logic signed [EB-1:0] e2_reg [3];
    logic signed [EB-1:0] e1_next [3];
    logic signed [EB-1:0] e2_next [3];

    logic signed [PB-1:0] prod_reg [6];
    logic signed [PB-1:0] prod_next [6];

    logic signed [XB-1:0] cross_c [3];
    logic [XB-1:0]        cross_abs [3];
    logic [MB-1:0]        mag_reg [3];
    logic [MB-1:0]        mag_next [3];
    logic [2:0]           neg3_reg, neg3_next;

    logic [2*HB-1:0]      hh_reg [3], hl_reg [3], ll_reg [3];
    logic [2*HB-1:0]      hh_next [3], hl_next [3], ll_next [3];
    logic [2:0]           neg4_reg;

    logic [SQW-1:0]       sq_reg [3];
    logic [SQW-1:0]       sq_next [3];
    logic [2:0]           neg5_reg;

    tnaa_pkg::front_out_t out_reg, out_next;

    assign a_c[0] = in_data.a_x;
    assign a_c[1] = in_data.a_y;
    assign a_c[2] = in_data.a_z;
    assign b_c[0] = in_data.b_x;
    assign b_c[1] = in_data.b_y;
    assign b_c[2] = in_data.b_z;
    assign c_c[0] = in_data.c_x;
    assign c_c[1] = in_data.c_y;
    assign c_c[2] = in_data.c_z;

    // Stage 1: edges
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            e1_next[k] = EB'(b_c[k]) - EB'(a_c[k]);
            e2_next[k] = EB'(c_c[k]) - EB'(a_c[k]);
        end
    end

    // Stage 2: the edge products for the cross product
    always_comb begin
        prod_next[0] = e1_reg[1] * e2_reg[2];
        prod_next[1] = e1_reg[2] * e2_reg[1];
        prod_next[2] = e1_reg[2] * e2_reg[0];
        prod_next[3] = e1_reg[0] * e2_reg[2];
        prod_next[4] = e1_reg[0] * e2_reg[1];
        prod_next[5] = e1_reg[1] * e2_reg[0];
    end

    // Stage 3: cross product, kept as magnitude and sign
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cross_c[k]   = XB'(prod_reg[2*k]) - XB'(prod_reg[2*k+1]);
            cross_abs[k] = cross_c[k][XB-1] ? -cross_c[k] : cross_c[k];
            mag_next[k]  = cross_abs[k][MB-1:0];
            neg3_next[k] = cross_c[k][XB-1];
        end
    end

    // Stage 4: partial products of each square
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            hh_next[k] = mag_reg[k][MB-1:HB] * mag_reg[k][MB-1:HB];
            hl_next[k] = mag_reg[k][MB-1:HB] * mag_reg[k][HB-1:0];
            ll_next[k] = mag_reg[k][HB-1:0]  * mag_reg[k][HB-1:0];
        end
    end

    // Stage 5: combine partial products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sq_next[k] = (SQW'(hh_reg[k]) << (2*HB)) + (SQW'(hl_reg[k]) << (HB+1))
                       + SQW'(ll_reg[k]);
        end
    end

    // Stage 6: sum of squares, zero test
    always_comb begin
        out_next.sum_sq = SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);
        for (int k = 0; k < 3; k++) begin
            out_next.mag_sq[k] = sq_reg[k];
        end
        out_next.neg  = neg5_reg;
        out_next.zero = ((sq_reg[0] | sq_reg[1] | sq_reg[2]) == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg    <= e1_next;
            e2_reg    <= e2_next;
            prod_reg  <= prod_next;
            mag_reg   <= mag_next;
            neg3_reg  <= neg3_next;
            hh_reg    <= hh_next;
            hl_reg    <= hl_next;
            ll_reg    <= ll_next;
            neg4_reg  <= neg3_reg;
            sq_reg    <= sq_next;
            neg5_reg  <= neg4_reg;
            out_reg   <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

[hdl/tnaa_sqrt_cell.sv]
// One bit of a restoring integer square root, registered.
// No package dependency; chained by the top level, one cell per root bit.
module tnaa_sqrt_cell #(
    parameter int RAD_W   = 2,
    parameter int ROOT_W  = 1,
    parameter int BIT_POS = 0,
    parameter int SIDE_W  = 1
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [RAD_W-1:0]  rem_in,
    input  logic [ROOT_W-1:0] root_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic [RAD_W-1:0]  rem_out,
    output logic [ROOT_W-1:0] root_out,
    output logic [SIDE_W-1:0] side_out
);

    localparam int TW = 2 * ROOT_W + 1;

    logic [TW-1:0]     trial;
    logic [TW-1:0]     rem_ext;
    logic              fits;
    logic [RAD_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [SIDE_W-1:0] side_reg;

    // trial = 2 * root * 2^b + 4^b; subtract when it fits
    always_comb begin
        trial     = (TW'(root_in) << (BIT_POS + 1)) + (TW'(1) << (2 * BIT_POS));
        rem_ext   = TW'(rem_in);
        fits      = (rem_ext >= trial);
        rem_next  = fits ? RAD_W'(rem_ext - trial) : rem_in;
        root_next = fits ? (root_in | (ROOT_W'(1) << BIT_POS)) : root_in;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

[hdl/tnaa_div_cell.sv]
// One quotient bit of a restoring divider, registered.
// No package dependency; chained by the top level, one cell per quotient bit.
module tnaa_div_cell #(
    parameter int DIV_W  = 2,
    parameter int QUO_W  = 2,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [DIV_W:0]    rem_in,
    input  logic [DIV_W-1:0]  div_in,
    input  logic [QUO_W-1:0]  quo_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic [DIV_W:0]    rem_out,
    output logic [DIV_W-1:0]  div_out,
    output logic [QUO_W-1:0]  quo_out,
    output logic [SIDE_W-1:0] side_out
);

    logic              fits;
    logic [DIV_W:0]    diff;
    logic [DIV_W:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]  div_reg;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [SIDE_W-1:0] side_reg;

    // Compare, subtract, shift the remainder for the next bit
    always_comb begin
        fits     = (rem_in >= {1'b0, div_in});
        diff     = fits ? (rem_in - {1'b0, div_in}) : rem_in;
        rem_next = {diff[DIV_W-1:0], 1'b0};
        quo_next = {quo_in[QUO_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            div_reg  <= div_in;
            quo_reg  <= quo_next;
            side_reg <= side_in;
        end
    end

    assign rem_out  = rem_reg;
    assign div_out  = div_reg;
    assign quo_out  = quo_reg;
    assign side_out = side_reg;

endmodule

[hdl/triangle_normal_and_area_top.sv]
// Top level: triangle face normal and cross product length.
// Depends on tnaa_pkg, tnaa_front, tnaa_sqrt_cell, tnaa_div_cell.
//
//   channel  | direction | handshake          | payload
//   s_       | in        | s_valid / s_ready  | s_data  (tnaa_pkg::tri_in_t)
//   m_       | out       | m_valid / m_ready  | m_data  (tnaa_pkg::tri_out_t)
//
// One triangle per cycle while the output is not stalled. Between input transfer and
// output lie the front end, the length root chain, the divide and root chains of the
// normal lanes, the final stage and the output register; the chains give one bit per cell.
// Synchronous active-low reset clears the stage valids, the skid valid and the output valid.
// A stalled output fills the skid register; the chain then holds until it drains.
module triangle_normal_and_area_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tnaa_pkg::tri_in_t     s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tnaa_pkg::tri_out_t    m_data
);

    localparam int SUMW  = tnaa_pkg::SUM_W;
    localparam int RB    = tnaa_pkg::ROOT_BITS;
    localparam int QB    = tnaa_pkg::QUO_BITS;
    localparam int DRB   = tnaa_pkg::DROOT_BITS;
    localparam int NB    = tnaa_pkg::NORM_BITS;
    localparam int LB    = tnaa_pkg::LEN_BITS;
    localparam int LW    = tnaa_pkg::LEN_W;
    localparam int FSW   = $bits(tnaa_pkg::front_out_t);
    localparam int LSW   = $bits(tnaa_pkg::lane_side_t);
    localparam int LAT   = tnaa_pkg::FRONT_STAGES + RB + QB + DRB + 1;

    logic                 en;
    logic                 fire;
    logic                 out_free;
    logic [LAT-1:0]       vld_reg, vld_next;

    tnaa_pkg::front_out_t front_q;

    // Length root chain
    logic [SUMW-1:0]      a_rem  [RB+1];
    logic [RB-1:0]        a_root [RB+1];
    logic [FSW-1:0]       a_side [RB+1];
    tnaa_pkg::front_out_t a_end;

    // Normal lanes: divide chain then root chain
    logic [SUMW:0]        b_rem  [3][QB+1];
    logic [SUMW-1:0]      b_div  [3][QB+1];
    logic [QB-1:0]        b_quo  [3][QB+1];
    logic [LSW-1:0]       b_side [3][QB+1];
    logic [QB-1:0]        d_rem  [3][DRB+1];
    logic [DRB-1:0]       d_root [3][DRB+1];
    logic [LSW-1:0]       d_side [3][DRB+1];

    tnaa_pkg::lane_side_t lane_end [3];
    logic [NB-1:0]        rnd  [3];
    logic [NB-1:0]        norm [3];
    logic [LW-1:0]        len_ext;

    tnaa_pkg::tri_out_t   fin_reg, fin_next;
    tnaa_pkg::tri_out_t   m_data_reg, m_data_next;
    tnaa_pkg::tri_out_t   skid_reg, skid_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 skid_valid_reg, skid_valid_next;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    tnaa_front u_front (
        .aclk     (aclk),
        .en       (en),
        .in_data  (s_data),
        .out_data (front_q)
    );

    // Length root: one cell per root bit
    assign a_rem[0]  = front_q.sum_sq;
    assign a_root[0] = '0;
    assign a_side[0] = front_q;

    for (genvar i = 0; i < RB; i++) begin : g_len
        tnaa_sqrt_cell #(
            .RAD_W   (SUMW),
            .ROOT_W  (RB),
            .BIT_POS (RB - 1 - i),
            .SIDE_W  (FSW)
        ) u_cell (
            .aclk     (aclk),
            .en       (en),
            .rem_in   (a_rem[i]),
            .root_in  (a_root[i]),
            .side_in  (a_side[i]),
            .rem_out  (a_rem[i+1]),
            .root_out (a_root[i+1]),
            .side_out (a_side[i+1])
        );
    end

    assign a_end = a_side[RB];

    // Per component: 2^30 * m^2 / sum, then its square root
    for (genvar k = 0; k < 3; k++) begin : g_lane
        tnaa_pkg::lane_side_t lane_start;

        always_comb begin
            lane_start.len  = a_root[RB];
            lane_start.neg  = a_end.neg[k];
            lane_start.zero = a_end.zero;
        end

        assign b_rem[k][0]  = (SUMW+1)'(a_end.mag_sq[k]);
        assign b_div[k][0]  = a_end.sum_sq;
        assign b_quo[k][0]  = '0;
        assign b_side[k][0] = lane_start;

        for (genvar i = 0; i < QB; i++) begin : g_div
            tnaa_div_cell #(
                .DIV_W  (SUMW),
                .QUO_W  (QB),
                .SIDE_W (LSW)
            ) u_cell (
                .aclk     (aclk),
                .en       (en),
                .rem_in   (b_rem[k][i]),
                .div_in   (b_div[k][i]),
                .quo_in   (b_quo[k][i]),
                .side_in  (b_side[k][i]),
                .rem_out  (b_rem[k][i+1]),
                .div_out  (b_div[k][i+1]),
                .quo_out  (b_quo[k][i+1]),
                .side_out (b_side[k][i+1])
            );
        end

        assign d_rem[k][0]  = b_quo[k][QB];
        assign d_root[k][0] = '0;
        assign d_side[k][0] = b_side[k][QB];

        for (genvar i = 0; i < DRB; i++) begin : g_root
            tnaa_sqrt_cell #(
                .RAD_W   (QB),
                .ROOT_W  (DRB),
                .BIT_POS (DRB - 1 - i),
                .SIDE_W  (LSW)
            ) u_cell (
                .aclk     (aclk),
                .en       (en),
                .rem_in   (d_rem[k][i]),
                .root_in  (d_root[k][i]),
                .side_in  (d_side[k][i]),
                .rem_out  (d_rem[k][i+1]),
                .root_out (d_root[k][i+1]),
                .side_out (d_side[k][i+1])
            );
        end

        // round to nearest: (isqrt + 1) / 2, then apply the sign
        always_comb begin
            lane_end[k] = d_side[k][DRB];
            rnd[k]      = NB'((DRB'(1) + (DRB+1)'(d_root[k][DRB]) + (DRB+1)'(0)) >> 1);
            norm[k]     = lane_end[k].neg ? -rnd[k] : rnd[k];
        end
    end

    // Final stage: degenerate override and length saturation
    always_comb begin
        len_ext = LW'(lane_end[0].len);
        fin_next.normal_x = lane_end[0].zero ? '0 : norm[0];
        fin_next.normal_y = lane_end[0].zero ? '0 : norm[1];
        fin_next.normal_z = lane_end[0].zero ? '0 : norm[2];
        if (lane_end[0].zero) begin
            fin_next.cross_length = '0;
        end else if (len_ext > LW'(tnaa_pkg::LEN_MAX)) begin
            fin_next.cross_length = tnaa_pkg::LEN_MAX;
        end else begin
            fin_next.cross_length = LB'(len_ext);
        end
        fin_next.degenerate = lane_end[0].zero;
    end

    // Stage valids
    assign vld_next = {vld_reg[LAT-2:0], s_valid};
    assign fire     = en && vld_reg[LAT-1];
    assign out_free = !m_valid_reg || m_ready;

    // Output register with skid stage
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                m_data_next     = skid_reg;
                m_valid_next    = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = fire;
                if (fire) begin
                    m_data_next = fin_reg;
                end
            end
        end else if (fire) begin
            skid_valid_next = 1'b1;
            skid_next       = fin_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg        <= '0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                vld_reg <= vld_next;
            end
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_reg <= fin_next;
        end
        m_data_reg <= m_data_next;
        skid_reg   <= skid_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hdl/tnaa_checker.sv]
// Port-level checks for the triangle normal and area block, bound to the top.
// Depends on tnaa_pkg and triangle_normal_and_area_top.
module tnaa_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input tnaa_pkg::tri_in_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input tnaa_pkg::tri_out_t m_data
);

    // Output transfer held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Degenerate results carry zero normal and zero length
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.normal_x == '0 && m_data.normal_y == '0 &&
            m_data.normal_z == '0 && m_data.cross_length == '0)
        else $error("degenerate result not zeroed");

    // Non-degenerate results have a length and components within one
    a_normal_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.degenerate |->
            m_data.cross_length != '0 &&
            m_data.normal_x >= -tnaa_pkg::ONE_Q14 && m_data.normal_x <= tnaa_pkg::ONE_Q14 &&
            m_data.normal_y >= -tnaa_pkg::ONE_Q14 && m_data.normal_y <= tnaa_pkg::ONE_Q14 &&
            m_data.normal_z >= -tnaa_pkg::ONE_Q14 && m_data.normal_z <= tnaa_pkg::ONE_Q14)
        else $error("normal component out of range or zero length");

endmodule

bind triangle_normal_and_area_top tnaa_checker u_tnaa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
